// File: rtl/min_max_envelope_history_core_assert.svh
// Assertion macros used by the envelope history core.
`ifndef MIN_MAX_ENVELOPE_HISTORY_CORE_ASSERT_SVH
`define MIN_MAX_ENVELOPE_HISTORY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMEH_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("envelope history check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MMEH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("envelope history check failed in the next cycle");

`endif

// File: rtl/mmeh_pkg.sv
`default_nettype none

package mmeh_pkg;

	localparam int VAL_W = 8;
	localparam int IDX_W = 7;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic REG_WINDOW_LOW  = 1'b0;
	localparam logic REG_WINDOW_HIGH = 1'b1;

	localparam logic [VAL_W-1:0] WINDOW_LOW_RESET  = 8'd127;
	localparam logic [VAL_W-1:0] WINDOW_HIGH_RESET = 8'd167;

	typedef logic [VAL_W-1:0] value_t;
	typedef logic [IDX_W-1:0] slot_idx_t;

	typedef struct packed {
		slot_idx_t slot;
		value_t    lo;
		value_t    hi;
	} fold_t;

endpackage

`default_nettype wire

// File: rtl/mmeh_fold.sv
`default_nettype none

module mmeh_fold #(
	parameter int SLOTS = 80
) (
	input  wire logic              advance,
	input  wire mmeh_pkg::value_t  sample,
	input  wire logic [$clog2(SLOTS)-1:0] cur_slot,
	input  wire mmeh_pkg::value_t  cur_lo,
	input  wire mmeh_pkg::value_t  cur_hi,
	output mmeh_pkg::fold_t        result
);

	localparam int CW = $clog2(SLOTS);
	localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

	logic [CW-1:0]    next_slot;
	mmeh_pkg::value_t base_lo;
	mmeh_pkg::value_t base_hi;

	// A tick with link_up seeds the new slot with the old range swapped so bars join up.
	always_comb begin
		next_slot = cur_slot;
		base_lo   = cur_lo;
		base_hi   = cur_hi;
		if (advance) begin
			next_slot = (cur_slot == LAST) ? '0 : cur_slot + CW'(1);
			base_lo   = cur_hi;
			base_hi   = cur_lo;
		end
		result.slot = mmeh_pkg::IDX_W'(next_slot);
		result.lo   = (sample < base_lo) ? sample : base_lo;
		result.hi   = (sample > base_hi) ? sample : base_hi;
	end

endmodule

`default_nettype wire

// File: rtl/mmeh_store.sv
`default_nettype none

module mmeh_store #(
	parameter int SLOTS = 80
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [$clog2(SLOTS)-1:0]  wr_addr,
	input  wire mmeh_pkg::value_t          wr_lo,
	input  wire mmeh_pkg::value_t          wr_hi,
	input  wire logic                      rd_en,
	input  wire mmeh_pkg::slot_idx_t       rd_addr,
	output mmeh_pkg::value_t               rd_lo,
	output mmeh_pkg::value_t               rd_hi
);

	localparam int CW = $clog2(SLOTS);
	localparam int DW = 2 * mmeh_pkg::VAL_W;

	logic [DW-1:0]    mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [DW-1:0]    rd_data_q;
	logic             rd_hit_q;
	logic             rd_in_range;

	assign rd_in_range = ({1'b0, rd_addr} < (mmeh_pkg::IDX_W + 1)'(SLOTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_lo, wr_hi};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[CW-1:0]];
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= rd_in_range && valid_q[rd_addr[CW-1:0]];
			end
		end
	end

	assign rd_lo = rd_hit_q ? rd_data_q[DW-1:mmeh_pkg::VAL_W] : '0;
	assign rd_hi = rd_hit_q ? rd_data_q[mmeh_pkg::VAL_W-1:0] : '0;

endmodule

`default_nettype wire

// File: rtl/min_max_envelope_history_core.sv
// Min/max envelope history ring.
// Input channel: in_valid/in_stall with cmd, sample, link_up and read_index.
// A request is taken at a rising edge with in_valid high and in_stall low.
// Sample and tick requests update the current slot and return its new range
// and the cursor; read requests return a stored slot clamped to the window.
// An unused command is taken and produces no result.
// Output channel: out_valid/out_stall with slot_min, slot_max, slot_number.
// Results pass s1 and the output register. One request is taken every cycle
// while in_stall is low; the current slot lives in registers, so a tick
// needs no memory read, and the slot memory has one write and one read port.
// Configuration: cfg_valid/cfg_ready (always ready); cfg_index selects window
// low (0) or high (1) register; user writes only while idle, not enforced.
// Reset clears the cursor, the current slot and every slot valid bit, so all
// slots read as zero; the window returns to 127..167. No clearing pass runs.
// When out_stall holds a result, one more request is taken into the middle
// stage, then in_stall rises until the output is taken.
`default_nettype none
`include "min_max_envelope_history_core_assert.svh"

module min_max_envelope_history_core #(
	parameter int SLOTS = 80
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic [7:0]          sample,
	input  wire logic                link_up,
	input  wire logic [6:0]          read_index,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [7:0]               slot_min,
	output logic [7:0]               slot_max,
	output logic [6:0]               slot_number,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_data
);

	localparam int CW = $clog2(SLOTS);
	localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

	mmeh_pkg::value_t    window_low_q;
	mmeh_pkg::value_t    window_high_q;

	logic [CW-1:0]       cur_q;
	mmeh_pkg::value_t    cur_lo_q;
	mmeh_pkg::value_t    cur_hi_q;

	logic                s1_valid_q;
	logic                is_read_s1;
	mmeh_pkg::value_t    lo_s1;
	mmeh_pkg::value_t    hi_s1;
	mmeh_pkg::slot_idx_t slot_s1;

	logic                out_valid_q;
	mmeh_pkg::value_t    slot_min_q;
	mmeh_pkg::value_t    slot_max_q;
	mmeh_pkg::slot_idx_t slot_number_q;

	logic                accept;
	logic                out_ready;
	logic                is_update;
	logic                advance;
	mmeh_pkg::fold_t     fold;
	mmeh_pkg::value_t    rd_lo;
	mmeh_pkg::value_t    rd_hi;
	mmeh_pkg::value_t    res_min;
	mmeh_pkg::value_t    res_max;

	function automatic mmeh_pkg::value_t clamp(input mmeh_pkg::value_t v,
		input mmeh_pkg::value_t lo, input mmeh_pkg::value_t hi);
		mmeh_pkg::value_t r;
		r = (v < hi) ? v : hi;
		return (r > lo) ? r : lo;
	endfunction

	assign out_ready = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !out_ready;
	assign accept    = in_valid && !in_stall;
	assign is_update = (cmd == mmeh_pkg::CMD_SAMPLE) || (cmd == mmeh_pkg::CMD_TICK);
	assign advance   = (cmd == mmeh_pkg::CMD_TICK) && link_up;
	assign cfg_ready = 1'b1;

	mmeh_fold #(
		.SLOTS(SLOTS)
	) u_fold (
		.advance (advance),
		.sample  (sample),
		.cur_slot(cur_q),
		.cur_lo  (cur_lo_q),
		.cur_hi  (cur_hi_q),
		.result  (fold)
	);

	mmeh_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && is_update),
		.wr_addr(fold.slot[CW-1:0]),
		.wr_lo  (fold.lo),
		.wr_hi  (fold.hi),
		.rd_en  (accept && (cmd == mmeh_pkg::CMD_READ)),
		.rd_addr(read_index),
		.rd_lo  (rd_lo),
		.rd_hi  (rd_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= mmeh_pkg::WINDOW_LOW_RESET;
			window_high_q <= mmeh_pkg::WINDOW_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mmeh_pkg::REG_WINDOW_LOW:  window_low_q  <= cfg_data;
				mmeh_pkg::REG_WINDOW_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			cur_lo_q <= '0;
			cur_hi_q <= '0;
		end else if (accept && is_update) begin
			cur_q    <= fold.slot[CW-1:0];
			cur_lo_q <= fold.lo;
			cur_hi_q <= fold.hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= (cmd != mmeh_pkg::CMD_NONE);
		end else if (out_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1 <= (cmd == mmeh_pkg::CMD_READ);
			lo_s1      <= fold.lo;
			hi_s1      <= fold.hi;
			slot_s1    <= (cmd == mmeh_pkg::CMD_READ) ? read_index : fold.slot;
		end
	end

	assign res_min = is_read_s1 ? clamp(rd_lo, window_low_q, window_high_q) : lo_s1;
	assign res_max = is_read_s1 ? clamp(rd_hi, window_low_q, window_high_q) : hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s1_valid_q) begin
			slot_min_q    <= res_min;
			slot_max_q    <= res_max;
			slot_number_q <= slot_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_min    = slot_min_q;
	assign slot_max    = slot_max_q;
	assign slot_number = slot_number_q;

	`MMEH_ASSERT_SAME(a_cursor_in_range, 1'b1, cur_q <= LAST)
	`MMEH_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid_q && out_valid_q && out_stall)
	`MMEH_ASSERT_NEXT(a_unused_cmd_no_result, accept && (cmd == mmeh_pkg::CMD_NONE), !s1_valid_q)
	`MMEH_ASSERT_NEXT(a_tick_wraps, accept && advance && (cur_q == LAST), cur_q == '0)

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
	import mmeh_pkg::*;

	localparam int SLOTS = 80;
	localparam int LIMIT = 1000000;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_REQUESTS = 322;

	typedef struct packed {
		logic [1:0] op;
		value_t     sample;
		logic       link;
		slot_idx_t  ridx;
	} request_t;

	typedef struct packed {
		value_t    lo;
		value_t    hi;
		slot_idx_t slot;
	} envelope_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] cmd = CMD_SAMPLE;
	logic [7:0] sample = '0;
	logic link_up = 1'b0;
	logic [6:0] read_index = '0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_index = REG_WINDOW_LOW;
	logic [7:0] cfg_data = '0;
	logic in_stall;
	logic out_valid;
	logic [7:0] slot_min;
	logic [7:0] slot_max;
	logic [6:0] slot_number;
	logic cfg_ready;

	min_max_envelope_history_core #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.sample(sample),
		.link_up(link_up),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slot_min(slot_min),
		.slot_max(slot_max),
		.slot_number(slot_number),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the slot ring, the cursor and the display window.
	value_t env_lo [SLOTS];
	value_t env_hi [SLOTS];
	slot_idx_t cursor = '0;
	value_t win_lo = WINDOW_LOW_RESET;
	value_t win_hi = WINDOW_HIGH_RESET;

	request_t pending[$];
	envelope_t envelope_due[$];
	int issued = 0;
	int accepted = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int src_idle_pct = 20;
	int sink_idle_pct = 20;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int sink_gap = 0;
	value_t band_base = 8'd100;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap(input int idle_pct);
		if ($urandom_range(0, 99) >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic value_t clamp_to_window(input value_t v);
		value_t r;
		r = (v < win_hi) ? v : win_hi;
		return (r > win_lo) ? r : win_lo;
	endfunction

	task automatic fold_request(input request_t rq, output envelope_t res, output bit has_result);
		slot_idx_t nxt;
		value_t lo;
		value_t hi;
		has_result = 1'b1;
		res = '0;
		case (rq.op)
			CMD_READ: begin
				lo = '0;
				hi = '0;
				if (rq.ridx < SLOTS) begin
					lo = env_lo[rq.ridx];
					hi = env_hi[rq.ridx];
				end
				res.lo = clamp_to_window(lo);
				res.hi = clamp_to_window(hi);
				res.slot = rq.ridx;
			end
			CMD_NONE: begin
				has_result = 1'b0;
			end
			default: begin
				if (rq.op == CMD_TICK && rq.link) begin
					nxt = (cursor == SLOTS - 1) ? '0 : cursor + 1'b1;
					env_lo[nxt] = env_hi[cursor];
					env_hi[nxt] = env_lo[cursor];
					cursor = nxt;
				end
				if (rq.sample < env_lo[cursor])
					env_lo[cursor] = rq.sample;
				if (rq.sample > env_hi[cursor])
					env_hi[cursor] = rq.sample;
				res.lo = env_lo[cursor];
				res.hi = env_hi[cursor];
				res.slot = cursor;
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d on %s: got %0d, want %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : request_driver
		request_t offered;
		envelope_t res;
		bit has_result;
		bit busy;
		int src_gap;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				fold_request(offered, res, has_result);
				if (has_result)
					envelope_due.push_back(res);
				accepted++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending.size() > 0) begin
					offered = pending.pop_front();
					cmd <= offered.op;
					sample <= offered.sample;
					link_up <= offered.link;
					read_index <= offered.ridx;
					busy = 1'b1;
					src_gap = pick_gap(src_idle_pct);
				end
			end
			in_valid <= busy;
		end else begin
			src_gap = 0;
		end
	end

	always @(posedge clk) begin : sink_side
		int gap;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			out_stall <= 1'b1;
		end else begin
			gap = pick_gap(sink_idle_pct);
			out_stall <= (gap > 0);
			sink_gap <= (gap > 0) ? gap - 1 : 0;
		end
	end

	always @(posedge clk) begin : result_monitor
		envelope_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (envelope_due.size() == 0) begin
				report_mismatch("result with none due, slot_number", slot_number, 0);
			end else begin
				want = envelope_due.pop_front();
				if (slot_min !== want.lo)
					report_mismatch("slot_min", slot_min, want.lo);
				if (slot_max !== want.hi)
					report_mismatch("slot_max", slot_max, want.hi);
				if (slot_number !== want.slot)
					report_mismatch("slot_number", slot_number, want.slot);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_request(input logic [1:0] op, input value_t smp, input logic link,
			input slot_idx_t ridx);
		request_t rq;
		rq.op = op;
		rq.sample = smp;
		rq.link = link;
		rq.ridx = ridx;
		pending.push_back(rq);
		issued++;
	endtask

	task automatic queue_random_requests(input int count);
		int useful;
		int pick;
		logic [1:0] op;
		value_t smp;
		slot_idx_t ridx;
		useful = 0;
		while (useful < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				op = CMD_SAMPLE;
			else if (pick < 65)
				op = CMD_TICK;
			else if (pick < 95)
				op = CMD_READ;
			else
				op = CMD_NONE;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				smp = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else if (pick < 4)
				smp = value_t'($urandom_range(0, 255));
			else
				smp = band_base + value_t'($urandom_range(0, 47));
			if ($urandom_range(0, 9) == 0)
				ridx = slot_idx_t'($urandom_range(SLOTS, 127));
			else
				ridx = slot_idx_t'($urandom_range(0, SLOTS - 1));
			queue_request(op, smp, $urandom_range(0, 4) != 0, ridx);
			if (op != CMD_NONE)
				useful++;
		end
	endtask

	// An unused command leaves nothing to wait for, so the task idles on
	// after the last result to let it drain before the window changes.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (!(accepted == issued && envelope_due.size() == 0));
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(input logic idx, input value_t val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW_LOW)
			win_lo = val;
		else
			win_hi = val;
	endtask

	task automatic run_phase(input value_t lo, input value_t hi, input int src_pct,
			input int sink_pct, input bit long_hold);
		wait_idle();
		set_window(REG_WINDOW_LOW, lo);
		set_window(REG_WINDOW_HIGH, hi);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		band_base = value_t'($urandom_range(0, 208));
		if (long_hold)
			hold_requests++;
		queue_random_requests(PHASE_REQUESTS);
	endtask

	initial begin
		value_t lo;
		value_t hi;
		for (int i = 0; i < SLOTS; i++) begin
			env_lo[i] = '0;
			env_hi[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_request(CMD_READ, 8'd0, 1'b0, 7'd0);
		queue_request(CMD_READ, 8'd0, 1'b0, 7'd79);
		queue_request(CMD_READ, 8'd0, 1'b1, 7'd80);
		queue_request(CMD_READ, 8'd255, 1'b1, 7'd127);
		queue_request(CMD_SAMPLE, 8'd255, 1'b0, 7'd0);
		queue_request(CMD_SAMPLE, 8'd0, 1'b0, 7'd0);
		queue_request(CMD_TICK, 8'd100, 1'b0, 7'd0);
		queue_request(CMD_TICK, 8'd128, 1'b1, 7'd0);
		queue_request(CMD_SAMPLE, 8'd200, 1'b1, 7'd0);
		queue_request(CMD_SAMPLE, 8'd140, 1'b0, 7'd0);
		queue_request(CMD_TICK, 8'd0, 1'b1, 7'd0);
		queue_request(CMD_NONE, 8'd255, 1'b1, 7'd127);
		queue_request(CMD_NONE, 8'd0, 1'b0, 7'd0);
		queue_request(CMD_READ, 8'd0, 1'b0, 7'd1);
		queue_request(CMD_READ, 8'd0, 1'b0, 7'd2);
		queue_request(CMD_READ, 8'd0, 1'b0, 7'd0);
		queue_request(CMD_TICK, 8'd255, 1'b0, 7'd0);
		queue_request(CMD_SAMPLE, 8'd77, 1'b0, 7'd0);
		queue_request(CMD_READ, 8'd0, 1'b0, 7'd2);

		// The sender stops after each phase until every result is back.
		run_phase(WINDOW_LOW_RESET, WINDOW_HIGH_RESET, 25, 25, 1'b0);
		run_phase(8'd0, 8'd255, 0, 0, 1'b0);
		run_phase(8'd200, 8'd50, 0, 30, 1'b1);
		run_phase(8'd255, 8'd255, 60, 60, 1'b0);
		run_phase(8'd0, 8'd0, 10, 40, 1'b0);
		lo = value_t'($urandom_range(0, 200));
		hi = lo + value_t'($urandom_range(0, 255 - lo));
		run_phase(lo, hi, 30, 10, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
